// ===== hdl/priority_schedule_waiting_times_unit_macros.svh =====
// ---------------------------------------------------------------------------
// priority_schedule_waiting_times_unit_macros.svh
// Assertion macros for the priority schedule unit; empty for synthesis.
// ---------------------------------------------------------------------------
`ifndef PRIORITY_SCHEDULE_WAITING_TIMES_UNIT_MACROS_SVH
`define PRIORITY_SCHEDULE_WAITING_TIMES_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold on every rising clock edge outside reset
`define PSW_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// expression must never be true outside reset
`define PSW_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define PSW_ASSERT(lbl, clk, rst, prop, msg)
`define PSW_NEVER(lbl, clk, rst, expr, msg)
`endif

`endif

// ===== hdl/psw_pkg.sv =====
// ---------------------------------------------------------------------------
// psw_pkg
// Types, sizes and compare helpers shared by the priority schedule unit.
// ---------------------------------------------------------------------------
package psw_pkg;

   localparam int MAX_PROCS = 16;
   localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int CNT_W     = $clog2(MAX_PROCS + 1);
   localparam int ROT_CYC   = (MAX_PROCS > 1) ? MAX_PROCS - 1 : 1;
   localparam int STEP_W    = (ROT_CYC > 1) ? $clog2(ROT_CYC) : 1;

   localparam int BURST_W = 16;
   localparam int PRIO_W  = 8;
   localparam int TIME_W  = 20;
   localparam int PIDX_W  = 4;

   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   typedef struct packed {
      logic [BURST_W-1:0] burst;
      logic [PRIO_W-1:0]  prio;
      logic               is_last;
   } psw_req_type;

   typedef struct packed {
      logic [PIDX_W-1:0] proc_index;
      logic [TIME_W-1:0] waiting_time;
      logic [TIME_W-1:0] turnaround_time;
      logic              run_end;
      logic              dropped;
   } psw_rsp_type;

   typedef struct packed {
      logic [PRIO_W-1:0]  prio;
      logic [BURST_W-1:0] burst;
   } psw_proc_type;

   // circulating copy of one process
   typedef struct packed {
      logic               vld;
      logic [IDX_W-1:0]   idx;
      logic [PRIO_W-1:0]  prio;
      logic [BURST_W-1:0] burst;
   } psw_tok_type;

   typedef struct packed {
      logic init;
      logic rot;
      logic drain;
      logic last_out;
   } psw_ctl_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_INIT,
      ST_ROT,
      ST_DRAIN
   } psw_state_type;

   // true if process a is served ahead of process b
   function automatic logic goes_first(
      input logic [PRIO_W-1:0]  pa,
      input logic [BURST_W-1:0] ba,
      input logic [IDX_W-1:0]   ia,
      input logic [PRIO_W-1:0]  pb,
      input logic [BURST_W-1:0] bb,
      input logic [IDX_W-1:0]   ib
   );
      logic r;
      if (pa != pb) begin
         r = (pa > pb);
      end else if (ba != bb) begin
         r = (ba < bb);
      end else begin
         r = (ia < ib);
      end
      return r;
   endfunction

   function automatic logic [TIME_W-1:0] sat_add(
      input logic [TIME_W-1:0]  a,
      input logic [BURST_W-1:0] b
   );
      logic [TIME_W:0] s;
      s = {1'b0, a} + (TIME_W + 1)'(b);
      return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
   endfunction

endpackage

// ===== hdl/psw_cell.sv =====
// ---------------------------------------------------------------------------
// psw_cell
// One process slot: holds its process, passes a token around the ring and
// sums the bursts of every token that is served ahead of it.
// ---------------------------------------------------------------------------
module psw_cell (
   input  logic                          clock,
   input  psw_pkg::psw_ctl_type          ctl,
   input  logic [psw_pkg::IDX_W-1:0]     cell_idx,
   input  logic [psw_pkg::CNT_W-1:0]     n_procs,
   input  logic                          load_en,
   input  psw_pkg::psw_proc_type         load_data,
   input  psw_pkg::psw_tok_type          tok_prev,
   input  logic [psw_pkg::BURST_W-1:0]   nxt_burst,
   input  logic [psw_pkg::TIME_W-1:0]    nxt_acc,
   output psw_pkg::psw_tok_type          tok,
   output logic [psw_pkg::BURST_W-1:0]   own_burst,
   output logic [psw_pkg::TIME_W-1:0]    acc
);

   psw_pkg::psw_proc_type        own_ff, own_in;
   psw_pkg::psw_tok_type         tok_ff, tok_in;
   logic [psw_pkg::TIME_W-1:0]   acc_ff, acc_in;

   always_comb begin
      own_in = own_ff;
      tok_in = tok_ff;
      acc_in = acc_ff;
      if (load_en) begin
         own_in = load_data;
      end
      if (ctl.init) begin
         tok_in.vld   = (psw_pkg::CNT_W'(cell_idx) < n_procs);
         tok_in.idx   = cell_idx;
         tok_in.prio  = own_ff.prio;
         tok_in.burst = own_ff.burst;
         acc_in       = '0;
      end
      if (ctl.rot) begin
         tok_in = tok_prev;
         if (tok_prev.vld && psw_pkg::goes_first(tok_prev.prio, tok_prev.burst, tok_prev.idx,
                                                 own_ff.prio, own_ff.burst, cell_idx)) begin
            acc_in = psw_pkg::sat_add(acc_ff, tok_prev.burst);
         end
      end
      // results shift toward cell 0
      if (ctl.drain) begin
         own_in.burst = nxt_burst;
         acc_in       = nxt_acc;
      end
   end

   always_ff @(posedge clock) begin
      own_ff <= own_in;
      tok_ff <= tok_in;
      acc_ff <= acc_in;
   end

   assign tok       = tok_ff;
   assign own_burst = own_ff.burst;
   assign acc       = acc_ff;

endmodule

// ===== hdl/psw_ctrl.sv =====
// ---------------------------------------------------------------------------
// psw_ctrl
// Sequencer: load, token init, ring rotation, result drain.
// ---------------------------------------------------------------------------
`include "priority_schedule_waiting_times_unit_macros.svh"

module psw_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        last_acc,
   input  logic [psw_pkg::CNT_W-1:0]   n_procs,
   output psw_pkg::psw_ctl_type        ctl,
   output logic [psw_pkg::IDX_W-1:0]   out_idx,
   output logic                        busy
);

   psw_pkg::psw_state_type        state_ff, state_in;
   logic [psw_pkg::STEP_W-1:0]    step_ff, step_in;
   logic [psw_pkg::IDX_W-1:0]     out_ff, out_in;
   logic                          rot_done;
   logic                          out_last;

   assign rot_done = (step_ff == psw_pkg::STEP_W'(psw_pkg::ROT_CYC - 1));
   assign out_last = ((psw_pkg::CNT_W'(out_ff) + psw_pkg::CNT_W'(1)) == n_procs);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         psw_pkg::ST_LOAD: begin
            if (last_acc) state_in = psw_pkg::ST_INIT;
         end
         psw_pkg::ST_INIT: begin
            state_in = psw_pkg::ST_ROT;
         end
         psw_pkg::ST_ROT: begin
            if (rot_done) state_in = psw_pkg::ST_DRAIN;
         end
         psw_pkg::ST_DRAIN: begin
            if (out_last) state_in = psw_pkg::ST_LOAD;
         end
         default: begin
            state_in = psw_pkg::ST_LOAD;
         end
      endcase
   end

   always_comb begin
      ctl      = '0;
      busy     = 1'b1;
      step_in  = step_ff;
      out_in   = out_ff;
      case (state_ff)
         psw_pkg::ST_LOAD: begin
            busy = 1'b0;
         end
         psw_pkg::ST_INIT: begin
            ctl.init = 1'b1;
            step_in  = '0;
            out_in   = '0;
         end
         psw_pkg::ST_ROT: begin
            ctl.rot = 1'b1;
            step_in = step_ff + psw_pkg::STEP_W'(1);
         end
         psw_pkg::ST_DRAIN: begin
            ctl.drain    = 1'b1;
            ctl.last_out = out_last;
            out_in       = out_ff + psw_pkg::IDX_W'(1);
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= psw_pkg::ST_LOAD;
         step_ff  <= '0;
         out_ff   <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         out_ff   <= out_in;
      end
   end

   assign out_idx = out_ff;

   `PSW_ASSERT(a_init_then_rot, clock, reset, ctl.init |=> ctl.rot, "init not followed by rotation")
   `PSW_ASSERT(a_last_then_idle, clock, reset, ctl.last_out |=> !busy, "still busy after last word")
   `PSW_ASSERT(a_busy_fall, clock, reset, $fell(busy) |-> $past(ctl.last_out), "busy dropped early")
   `PSW_ASSERT(a_one_phase, clock, reset, $onehot0({ctl.init, ctl.rot, ctl.drain}), "phases overlap")

endmodule

// ===== hdl/priority_schedule_waiting_times_unit.sv =====
// ---------------------------------------------------------------------------
// priority_schedule_waiting_times_unit
// Non-preemptive-equivalent priority schedule of up to 16 processes that all
// arrive at time zero; reports waiting and turnaround time per process.
// ---------------------------------------------------------------------------
// Usage:
//   Raise start with req_word for one cycle per process while busy is low;
//   each word is taken in that cycle. The word with is_last set closes the
//   set. Words beyond 16 are dropped and flag the set.
//   After is_last, busy stays high: the init state copies every process into
//   a ring of cells, then the ring passes each token past every other cell
//   (the cell count, not the set size, sets its length), each cell adding the
//   bursts of those ahead of it. Then results leave in index order, one word
//   per cycle on rsp_word marked by rsp_strobe, read from cell 0 as the chain
//   shifts. The first result follows the init and rotation states; busy stays
//   high until the last result word has left.
//   Loading runs at one word per cycle.
//   The receiver cannot stall: each result word is valid for one cycle only.
//   Reset clears the set, the drop flag and the sequencer; stored processes
//   are simply overwritten by the next set.
// ---------------------------------------------------------------------------
module priority_schedule_waiting_times_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  psw_pkg::psw_req_type  req_word,
   output logic                  rsp_strobe,
   output psw_pkg::psw_rsp_type  rsp_word
);

   localparam int N = psw_pkg::MAX_PROCS;

   psw_pkg::psw_ctl_type              ctl;
   logic [psw_pkg::IDX_W-1:0]         out_idx;
   logic [psw_pkg::CNT_W-1:0]         cnt_ff, cnt_in;
   logic                              ovf_ff, ovf_in;
   logic                              acc_word;
   logic                              room;
   psw_pkg::psw_proc_type             load_data;

   psw_pkg::psw_tok_type              tok     [N];
   logic [psw_pkg::BURST_W-1:0]       burst_w [N];
   logic [psw_pkg::TIME_W-1:0]        acc_w   [N];

   logic [psw_pkg::TIME_W-1:0]        comp;
   logic [psw_pkg::TIME_W-1:0]        burst0;

   assign acc_word = start && !busy;
   assign room     = (cnt_ff < psw_pkg::CNT_W'(N));

   assign load_data.prio  = req_word.prio;
   assign load_data.burst = req_word.burst;

   always_comb begin
      cnt_in = cnt_ff;
      ovf_in = ovf_ff;
      if (acc_word) begin
         if (room) begin
            cnt_in = cnt_ff + psw_pkg::CNT_W'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end
      if (ctl.last_out) begin
         cnt_in = '0;
         ovf_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         ovf_ff <= ovf_in;
      end
   end

   psw_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .last_acc (acc_word && req_word.is_last),
      .n_procs  (cnt_ff),
      .ctl      (ctl),
      .out_idx  (out_idx),
      .busy     (busy)
   );

   for (genvar i = 0; i < N; i++) begin : g_cell
      psw_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .cell_idx  (psw_pkg::IDX_W'(i)),
         .n_procs   (cnt_ff),
         .load_en   (acc_word && room && (cnt_ff == psw_pkg::CNT_W'(i))),
         .load_data (load_data),
         .tok_prev  (tok[(i + N - 1) % N]),
         .nxt_burst (burst_w[(i + 1 < N) ? i + 1 : i]),
         .nxt_acc   (acc_w[(i + 1 < N) ? i + 1 : i]),
         .tok       (tok[i]),
         .own_burst (burst_w[i]),
         .acc       (acc_w[i])
      );
   end

   // cell 0 holds the process being reported
   assign burst0 = psw_pkg::TIME_W'(burst_w[0]);
   assign comp   = (burst_w[0] == '0) ? '0 : psw_pkg::sat_add(acc_w[0], burst_w[0]);

   assign rsp_strobe               = ctl.drain;
   assign rsp_word.proc_index      = psw_pkg::PIDX_W'(out_idx);
   assign rsp_word.turnaround_time = comp;
   assign rsp_word.waiting_time    = (comp >= burst0) ? comp - burst0 : '0;
   assign rsp_word.run_end         = ctl.last_out;
   assign rsp_word.dropped         = ovf_ff;

endmodule

// ===== bench/priority_schedule_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// priority_schedule_checker
// Watches the request and result channels of the priority schedule unit,
// rebuilds each process set, works out the schedule and checks every result
// word against it in order.
// ---------------------------------------------------------------------------
module priority_schedule_checker
   import psw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  psw_req_type req_word,
   input  logic        rsp_strobe,
   input  psw_rsp_type rsp_word,
   output int          fail_count,
   output int          open_results
);

   logic [BURST_W-1:0] burst_tab [MAX_PROCS];
   logic [PRIO_W-1:0]  prio_tab  [MAX_PROCS];
   int unsigned        proc_count  = 0;
   logic               set_dropped = 1'b0;
   psw_rsp_type        expected_times [$];
   int                 errs = 0;

   // run the loaded set to completion and queue one word per process
   function automatic void schedule_set();
      logic              served    [MAX_PROCS];
      logic [TIME_W-1:0] finish_at [MAX_PROCS];
      int unsigned       elapsed;
      int                best;
      logic              ahead;
      psw_rsp_type       r;
      for (int i = 0; i < MAX_PROCS; i++) begin
         served[i]    = 1'b0;
         finish_at[i] = '0;
      end
      elapsed = 0;
      for (int k = 0; k < proc_count; k++) begin
         best = -1;
         for (int i = 0; i < proc_count; i++) begin
            if (!served[i]) begin
               if (best < 0) begin
                  ahead = 1'b1;
               end else if (prio_tab[i] != prio_tab[best]) begin
                  ahead = (prio_tab[i] > prio_tab[best]);
               end else if (burst_tab[i] != burst_tab[best]) begin
                  ahead = (burst_tab[i] < burst_tab[best]);
               end else begin
                  // equal on both keys: the lower index already holds the slot
                  ahead = 1'b0;
               end
               if (ahead) best = i;
            end
         end
         served[best] = 1'b1;
         // a zero burst takes no time and finishes at zero
         if (burst_tab[best] != '0) begin
            elapsed = elapsed + 32'(burst_tab[best]);
            if (elapsed > 32'(TIME_MAX)) elapsed = 32'(TIME_MAX);
            finish_at[best] = TIME_W'(elapsed);
         end
      end
      for (int i = 0; i < proc_count; i++) begin
         r.proc_index      = PIDX_W'(i);
         r.turnaround_time = finish_at[i];
         r.waiting_time    = (finish_at[i] >= TIME_W'(burst_tab[i])) ?
                             finish_at[i] - TIME_W'(burst_tab[i]) : '0;
         r.run_end         = (i == proc_count - 1);
         r.dropped         = set_dropped;
         expected_times.push_back(r);
      end
      proc_count  = 0;
      set_dropped = 1'b0;
   endfunction

   always @(posedge clock) begin : watch
      psw_rsp_type want;
      if (reset) begin
         proc_count  = 0;
         set_dropped = 1'b0;
         expected_times.delete();
      end else begin
         if (rsp_strobe !== 1'b0) begin
            if (expected_times.size() == 0) begin
               errs++;
               if (errs <= 32)
                  $display("%0t unexpected result word: idx %0d wait %0d turn %0d end %0b drop %0b",
                           $time, rsp_word.proc_index, rsp_word.waiting_time,
                           rsp_word.turnaround_time, rsp_word.run_end, rsp_word.dropped);
            end else begin
               want = expected_times.pop_front();
               if (rsp_word !== want) begin
                  errs++;
                  if (errs <= 32) begin
                     $display("%0t mismatch expected: idx %0d wait %0d turn %0d end %0b drop %0b",
                              $time, want.proc_index, want.waiting_time,
                              want.turnaround_time, want.run_end, want.dropped);
                     $display("%0t mismatch actual:   idx %0d wait %0d turn %0d end %0b drop %0b",
                              $time, rsp_word.proc_index, rsp_word.waiting_time,
                              rsp_word.turnaround_time, rsp_word.run_end, rsp_word.dropped);
                  end
               end
            end
         end
         if (start && !busy) begin
            if (proc_count < MAX_PROCS) begin
               burst_tab[proc_count] = req_word.burst;
               prio_tab[proc_count]  = req_word.prio;
               proc_count++;
            end else begin
               set_dropped = 1'b1;
            end
            if (req_word.is_last) schedule_set();
         end
      end
      fail_count   <= errs;
      open_results <= expected_times.size();
   end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Drives process sets into the priority schedule unit: a few directed sets
// (extremes, ties, zero burst, a full set with a dropped word), then random
// sets under varying sender idling. The checker predicts and compares.
// ---------------------------------------------------------------------------
module testbench;
   import psw_pkg::*;

   localparam int IDLE_LIMIT   = 2000;
   localparam int RANDOM_WORDS = 480;
   localparam int TAIL_CYCLES  = 40;

   logic        clock    = 1'b0;
   logic        reset    = 1'b1;
   logic        start    = 1'b0;
   psw_req_type req_word = '0;
   logic        busy;
   logic        rsp_strobe;
   psw_rsp_type rsp_word;
   int          fail_count;
   int          open_results;
   int          idle_pct     = 0;
   int          stall_cycles = 0;

   priority_schedule_waiting_times_unit dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   priority_schedule_checker check (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_word     (req_word),
      .rsp_strobe   (rsp_strobe),
      .rsp_word     (rsp_word),
      .fail_count   (fail_count),
      .open_results (open_results)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // cycles with no word moving on either channel
   always @(posedge clock) begin
      if (reset) begin
         stall_cycles <= 0;
      end else if ((start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= IDLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // small values make ties on burst likely
   function automatic logic [BURST_W-1:0] pick_burst();
      logic [BURST_W-1:0] b;
      case ($urandom_range(9))
         0:       b = '0;
         1:       b = '1;
         2:       b = BURST_W'(1);
         3, 4, 5: b = BURST_W'($urandom_range(1, 8));
         default: b = BURST_W'($urandom_range(65535));
      endcase
      return b;
   endfunction

   function automatic logic [PRIO_W-1:0] pick_prio();
      logic [PRIO_W-1:0] p;
      case ($urandom_range(9))
         0:       p = '0;
         1:       p = '1;
         2, 3, 4: p = PRIO_W'($urandom_range(3));
         default: p = PRIO_W'($urandom_range(255));
      endcase
      return p;
   endfunction

   // leaves start high so back-to-back words need no extra step
   task automatic send_proc(input logic [BURST_W-1:0] b, input logic [PRIO_W-1:0] p,
                            input logic last);
      psw_req_type w;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      w.burst   = b;
      w.prio    = p;
      w.is_last = last;
      start    <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (open_results != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      int set_size;
      int sent;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      idle_pct = 36;
      send_proc('1, '1, 1'b1);
      send_proc('0, '0, 1'b1);
      // equal keys, then a shorter burst, then a zero burst at the same priority
      send_proc(16'd5, 8'd7, 1'b0);
      send_proc(16'd5, 8'd7, 1'b0);
      send_proc(16'd3, 8'd7, 1'b0);
      send_proc(16'd0, 8'd7, 1'b1);
      drain_results();
      // full set of longest bursts, then one more word that gets dropped
      for (int i = 0; i < MAX_PROCS; i++)
         send_proc('1, (i % 2) ? 8'hFF : 8'h00, 1'b0);
      send_proc(16'h1234, 8'h80, 1'b1);
      drain_results();

      sent = 0;
      while (sent < RANDOM_WORDS) begin
         idle_pct = (sent < RANDOM_WORDS / 3) ? 36 : (sent < 2 * RANDOM_WORDS / 3) ? 83 : 0;
         case ($urandom_range(9))
            0, 1, 2, 3, 4, 5, 6: set_size = $urandom_range(1, 6);
            7, 8:                set_size = $urandom_range(7, MAX_PROCS);
            default:             set_size = $urandom_range(MAX_PROCS + 1, MAX_PROCS + 4);
         endcase
         for (int i = 0; i < set_size; i++)
            send_proc(pick_burst(), pick_prio(), i == set_size - 1);
         sent += set_size;
         if ($urandom_range(19) == 0) drain_results();
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && open_results == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
